// ===== hw/rtl/fpli_pkg.sv =====
// package: shared constants, codes and controller/datapath link types
package fpli_pkg;

  localparam int MAX_POINTS_DEF   = 64;
  localparam int CHARGE_BITS_DEF  = 24;
  localparam int VOLTAGE_BITS_DEF = 16;
  localparam int FRAC_BITS        = 16;
  localparam int ACTION_BITS      = 2;
  localparam int STATUS_BITS      = 2;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_QUERY   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_BELOW = 2'd2,
    STAT_ABOVE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_POINT = 2'd1,
    MODE_SEG   = 2'd2
  } walk_mode_t;

  typedef enum logic [1:0] {
    SRC_ZERO   = 2'd0,
    SRC_POINT  = 2'd1,
    SRC_INTERP = 2'd2
  } res_src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_CHK,
    S_EQ_CHK,
    S_SEG_CHK,
    S_LOOP,
    S_NXT_CHK,
    S_DIV_START,
    S_DIV_RUN,
    S_MUL_START,
    S_MUL_RUN,
    S_APPLY,
    S_FIN
  } fsm_state_t;

  typedef struct packed {
    logic     capture;
    logic     mem_wr;
    logic     rd_en;
    logic     rd_next;
    logic     rd_zero;
    logic     cur_load;
    logic     nxt_load;
    logic     ncc_load;
    logic     cursor_clr;
    logic     cursor_inc;
    logic     walk_clr;
    logic     div_start;
    logic     mul_start;
    logic     res_load;
    res_src_t res_src;
    status_t  res_stat;
    logic     out_load;
  } fpli_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic at_last;
    logic q_lt_rd;
    logic q_eq_rd;
    logic q_lt_ncc;
    logic div_done;
    logic mul_done;
  } fpli_stat_t;

endpackage

// ===== hw/rtl/fpli_ifs.sv =====
// interfaces: item, result and configuration channels
interface fpli_item_if
  import fpli_pkg::*;
#(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int CHARGE_BITS  = CHARGE_BITS_DEF,
  parameter int VOLTAGE_BITS = VOLTAGE_BITS_DEF
);
  localparam int IDX_BITS = $clog2(MAX_POINTS);

  logic                    valid;
  logic                    ready;
  logic [ACTION_BITS-1:0]  action;
  logic [IDX_BITS-1:0]     point_index;
  logic [CHARGE_BITS-1:0]  charge;
  logic [VOLTAGE_BITS-1:0] voltage;

  modport source (output valid, output action, output point_index, output charge,
                  output voltage, input ready);
  modport sink   (input valid, input action, input point_index, input charge,
                  input voltage, output ready);
endinterface

interface fpli_result_if
  import fpli_pkg::*;
#(
  parameter int VOLTAGE_BITS = VOLTAGE_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [VOLTAGE_BITS-1:0] voltage_out;
  logic [STATUS_BITS-1:0]  status;

  modport source (output valid, output voltage_out, output status, input ready);
  modport sink   (input valid, input voltage_out, input status, output ready);
endinterface

interface fpli_cfg_if
  import fpli_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
);
  localparam int CNT_BITS = $clog2(MAX_POINTS + 1);

  logic                valid;
  logic                ready;
  logic [CNT_BITS-1:0] points_in_use;

  modport source (output valid, output points_in_use, input ready);
  modport sink   (input valid, input points_in_use, output ready);
endinterface

// ===== hw/rtl/fpli_ram.sv =====
// generic single-write, registered-read ram
module fpli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/fpli_ctrl.sv =====
// controller: walk sequencer, walk mode and output handshake
module fpli_ctrl
  import fpli_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [ACTION_BITS-1:0] action,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  fpli_stat_t             stat,
  output fpli_cmd_t              cmd
);

  fsm_state_t state, state_next;
  walk_mode_t mode, mode_next;
  logic       out_full;
  logic       in_fire;
  logic       slot_free;
  action_t    act;

  assign act       = action_t'(action);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_full || out_ready;
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= MODE_START;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      mode     <= mode_next;
      out_full <= (out_full && !out_ready) || cmd.out_load;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (act == ACT_QUERY) begin
            unique case (mode)
              MODE_SEG:   state_next = S_SEG_CHK;
              MODE_POINT: state_next = S_EQ_CHK;
              default:    state_next = stat.n_zero ? S_FIN : S_START_CHK;
            endcase
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_START_CHK: begin
        if (stat.q_lt_rd || stat.q_eq_rd) state_next = S_FIN;
        else                              state_next = S_LOOP;
      end
      S_EQ_CHK:    state_next = stat.q_eq_rd ? S_FIN : S_LOOP;
      S_SEG_CHK: begin
        if (stat.q_lt_ncc)     state_next = S_MUL_START;
        else if (stat.at_last) state_next = S_FIN;
        else                   state_next = S_EQ_CHK;
      end
      S_LOOP:      state_next = stat.at_last ? S_FIN : S_NXT_CHK;
      S_NXT_CHK: begin
        if (stat.q_lt_rd)      state_next = S_DIV_START;
        else if (stat.q_eq_rd) state_next = S_FIN;
        else                   state_next = S_LOOP;
      end
      S_DIV_START: state_next = S_DIV_RUN;
      S_DIV_RUN:   state_next = stat.div_done ? S_MUL_START : S_DIV_RUN;
      S_MUL_START: state_next = S_MUL_RUN;
      S_MUL_RUN:   state_next = stat.mul_done ? S_APPLY : S_MUL_RUN;
      S_APPLY:     state_next = S_FIN;
      S_FIN:       state_next = slot_free ? S_IDLE : S_FIN;
      default:     state_next = S_IDLE;
    endcase
  end

  // walk mode
  always_comb begin
    mode_next = mode;
    unique case (state)
      S_IDLE:      if (in_fire && act == ACT_RESTART) mode_next = MODE_START;
      S_START_CHK: if (!stat.q_lt_rd && stat.q_eq_rd) mode_next = MODE_POINT;
      S_EQ_CHK:    if (stat.q_eq_rd) mode_next = MODE_POINT;
      S_SEG_CHK:   if (!stat.q_lt_ncc && stat.at_last) mode_next = MODE_POINT;
      S_LOOP:      if (stat.at_last) mode_next = MODE_POINT;
      S_NXT_CHK: begin
        if (stat.q_lt_rd)      mode_next = MODE_SEG;
        else if (stat.q_eq_rd) mode_next = MODE_POINT;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.res_src  = SRC_ZERO;
    cmd.res_stat = STAT_OK;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.capture = 1'b1;
          unique case (act)
            ACT_LOAD: begin
              cmd.mem_wr   = 1'b1;
              cmd.res_load = 1'b1;
            end
            ACT_RESTART: begin
              cmd.cursor_clr = 1'b1;
              cmd.walk_clr   = 1'b1;
              cmd.res_load   = 1'b1;
            end
            ACT_NOP: cmd.res_load = 1'b1;
            ACT_QUERY: begin
              unique case (mode) inside
                MODE_SEG, MODE_POINT: cmd.rd_en = 1'b1;
                default: begin
                  cmd.cursor_clr = 1'b1;
                  if (stat.n_zero) begin
                    cmd.res_load = 1'b1;
                    cmd.res_stat = STAT_EMPTY;
                  end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_zero = 1'b1;
                  end
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      S_START_CHK: begin
        cmd.cur_load = 1'b1;
        if (stat.q_lt_rd) begin
          cmd.res_load = 1'b1;
          cmd.res_stat = STAT_BELOW;
        end else if (stat.q_eq_rd) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = SRC_POINT;
        end
      end
      S_EQ_CHK: begin
        cmd.cur_load = 1'b1;
        if (stat.q_eq_rd) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = SRC_POINT;
        end
      end
      S_SEG_CHK: begin
        cmd.cur_load = 1'b1;
        if (!stat.q_lt_ncc) begin
          if (stat.at_last) begin
            cmd.res_load = 1'b1;
            cmd.res_stat = STAT_ABOVE;
          end else begin
            cmd.cursor_inc = 1'b1;
            cmd.rd_en      = 1'b1;
            cmd.rd_next    = 1'b1;
          end
        end
      end
      S_LOOP: begin
        if (stat.at_last) begin
          cmd.res_load = 1'b1;
          cmd.res_stat = STAT_ABOVE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
        end
      end
      S_NXT_CHK: begin
        cmd.nxt_load = 1'b1;
        if (stat.q_lt_rd) begin
          cmd.ncc_load = 1'b1;
        end else begin
          cmd.cursor_inc = 1'b1;
          cmd.cur_load   = 1'b1;
          if (stat.q_eq_rd) begin
            cmd.res_load = 1'b1;
            cmd.res_src  = SRC_POINT;
          end
        end
      end
      S_DIV_START: cmd.div_start = 1'b1;
      S_MUL_START: cmd.mul_start = 1'b1;
      S_APPLY: begin
        cmd.res_load = 1'b1;
        cmd.res_src  = SRC_INTERP;
      end
      S_FIN:   cmd.out_load = slot_free;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_full) |-> $past(state) == S_FIN)
    else $error("result slot filled outside the finish state");

  a_seg_entry: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_SEG && $past(mode) != MODE_SEG) |-> $past(state) == S_NXT_CHK)
    else $error("segment mode entered without a right point check");

  a_apply_units_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY |-> (stat.div_done && stat.mul_done))
    else $error("interpolation applied while an arithmetic unit is busy");
`endif

endmodule

// ===== hw/rtl/fpli_dp.sv =====
// datapath: curve rams, cursor, slope divider, offset multiplier, result regs
module fpli_dp
  import fpli_pkg::*;
#(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int CHARGE_BITS  = CHARGE_BITS_DEF,
  parameter int VOLTAGE_BITS = VOLTAGE_BITS_DEF,
  localparam int IDX_BITS    = $clog2(MAX_POINTS),
  localparam int CNT_BITS    = $clog2(MAX_POINTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  fpli_cmd_t               cmd,
  output fpli_stat_t              stat,
  input  logic [IDX_BITS-1:0]     point_index,
  input  logic [CHARGE_BITS-1:0]  charge,
  input  logic [VOLTAGE_BITS-1:0] voltage,
  input  logic                    cfg_valid,
  input  logic [CNT_BITS-1:0]     cfg_points,
  output logic [VOLTAGE_BITS-1:0] voltage_out,
  output logic [STATUS_BITS-1:0]  status
);

  localparam int SLOPE_BITS = VOLTAGE_BITS + FRAC_BITS;
  localparam int PROD_BITS  = CHARGE_BITS + SLOPE_BITS;
  localparam int SH_BITS    = PROD_BITS - FRAC_BITS;
  localparam int DCNT_BITS  = $clog2(SLOPE_BITS + 1);
  localparam int MCNT_BITS  = $clog2(CHARGE_BITS + 1);

  logic [CNT_BITS-1:0]     piu;
  logic [CNT_BITS-1:0]     n_eff;
  logic [IDX_BITS-1:0]     cursor;
  logic [IDX_BITS-1:0]     rd_addr;
  logic                    wr_ok;
  logic [CHARGE_BITS-1:0]  rd_charge;
  logic [VOLTAGE_BITS-1:0] rd_volt;
  logic [CHARGE_BITS-1:0]  q_reg;
  logic [CHARGE_BITS-1:0]  cur_c, nxt_c, ncc;
  logic [VOLTAGE_BITS-1:0] cur_v, nxt_v;
  logic                    at_last;

  // divider
  logic                    div_busy;
  logic [DCNT_BITS-1:0]    div_cnt;
  logic [CHARGE_BITS-1:0]  div_rem;
  logic [CHARGE_BITS-1:0]  div_den;
  logic [SLOPE_BITS-1:0]   div_quo;
  logic                    slope_neg;
  logic [CHARGE_BITS:0]    rem_sh;
  logic                    rem_ge;
  logic                    dv_neg;
  logic [VOLTAGE_BITS-1:0] dv_mag;

  // multiplier
  logic                    mul_busy;
  logic [MCNT_BITS-1:0]    mul_cnt;
  logic [PROD_BITS-1:0]    mul_p;
  logic                    prod_neg;
  logic                    off_neg;
  logic [CHARGE_BITS-1:0]  off_mag;
  logic [SLOPE_BITS:0]     mul_add;

  // saturation
  logic [SH_BITS-1:0]      shifted;
  logic [SH_BITS:0]        up_sum;
  logic [VOLTAGE_BITS-1:0] interp_v;

  logic [VOLTAGE_BITS-1:0] res_v;
  status_t                 res_st;

  assign wr_ok = cmd.mem_wr && (CNT_BITS'(point_index) < CNT_BITS'(MAX_POINTS));

  always_comb begin
    if (cmd.rd_zero)      rd_addr = '0;
    else if (cmd.rd_next) rd_addr = cursor + IDX_BITS'(1);
    else                  rd_addr = cursor;
  end

  fpli_ram #(.WIDTH(CHARGE_BITS), .DEPTH(MAX_POINTS)) u_charge_ram (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (point_index),
    .wr_data (charge),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_charge)
  );

  fpli_ram #(.WIDTH(VOLTAGE_BITS), .DEPTH(MAX_POINTS)) u_volt_ram (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (point_index),
    .wr_data (voltage),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_volt)
  );

  assign n_eff   = (piu > CNT_BITS'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS) : piu;
  assign at_last = (CNT_BITS'(cursor) + CNT_BITS'(1)) >= n_eff;

  assign stat.n_zero   = (n_eff == '0);
  assign stat.at_last  = at_last;
  assign stat.q_lt_rd  = q_reg < rd_charge;
  assign stat.q_eq_rd  = q_reg == rd_charge;
  assign stat.q_lt_ncc = q_reg < ncc;
  assign stat.div_done = !div_busy;
  assign stat.mul_done = !mul_busy;

  // walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      piu    <= '0;
      cursor <= '0;
      ncc    <= '0;
    end else begin
      if (cfg_valid)           piu <= cfg_points;
      if (cmd.cursor_clr)      cursor <= '0;
      else if (cmd.cursor_inc) cursor <= cursor + IDX_BITS'(1);
      if (cmd.walk_clr)        ncc <= '0;
      else if (cmd.ncc_load)   ncc <= rd_charge;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) q_reg <= charge;
    if (cmd.cur_load) begin
      cur_c <= rd_charge;
      cur_v <= rd_volt;
    end
    if (cmd.nxt_load) begin
      nxt_c <= rd_charge;
      nxt_v <= rd_volt;
    end
  end

  // slope: restoring division of |dv| << 16 by dq, one quotient bit a cycle
  assign dv_neg = nxt_v < cur_v;
  assign dv_mag = dv_neg ? (cur_v - nxt_v) : (nxt_v - cur_v);
  assign rem_sh = {div_rem, div_quo[SLOPE_BITS-1]};
  assign rem_ge = rem_sh >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy  <= 1'b0;
      div_cnt   <= '0;
      div_quo   <= '0;
      slope_neg <= 1'b0;
    end else if (cmd.walk_clr) begin
      div_busy  <= 1'b0;
      div_quo   <= '0;
      slope_neg <= 1'b0;
    end else if (cmd.div_start) begin
      if (nxt_c > cur_c) begin
        div_busy  <= 1'b1;
        div_cnt   <= DCNT_BITS'(SLOPE_BITS);
        div_rem   <= '0;
        div_den   <= nxt_c - cur_c;
        div_quo   <= {dv_mag, {FRAC_BITS{1'b0}}};
        slope_neg <= dv_neg;
      end else begin
        div_busy  <= 1'b0;
        div_quo   <= '0;
        slope_neg <= 1'b0;
      end
    end else if (div_busy) begin
      div_rem <= rem_ge ? CHARGE_BITS'(rem_sh - {1'b0, div_den})
                        : rem_sh[CHARGE_BITS-1:0];
      div_quo <= {div_quo[SLOPE_BITS-2:0], rem_ge};
      div_cnt <= div_cnt - DCNT_BITS'(1);
      if (div_cnt == DCNT_BITS'(1)) div_busy <= 1'b0;
    end
  end

  // offset times slope magnitude, shift-add over the offset bits
  assign off_neg = q_reg < cur_c;
  assign off_mag = off_neg ? (cur_c - q_reg) : (q_reg - cur_c);
  assign mul_add = {1'b0, mul_p[PROD_BITS-1:CHARGE_BITS]}
                 + (mul_p[0] ? {1'b0, div_quo} : {(SLOPE_BITS+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_cnt  <= '0;
    end else if (cmd.mul_start) begin
      mul_busy <= 1'b1;
      mul_cnt  <= MCNT_BITS'(CHARGE_BITS);
      mul_p    <= {{SLOPE_BITS{1'b0}}, off_mag};
      prod_neg <= off_neg ^ slope_neg;
    end else if (mul_busy) begin
      mul_p   <= {mul_add, mul_p[CHARGE_BITS-1:1]};
      mul_cnt <= mul_cnt - MCNT_BITS'(1);
      if (mul_cnt == MCNT_BITS'(1)) mul_busy <= 1'b0;
    end
  end

  // truncate toward zero, add to the left voltage, clamp
  assign shifted = mul_p[PROD_BITS-1:FRAC_BITS];
  assign up_sum  = {1'b0, shifted} + (SH_BITS+1)'(cur_v);

  always_comb begin
    if (!prod_neg) begin
      interp_v = (up_sum[SH_BITS:VOLTAGE_BITS] != '0) ? '1 : up_sum[VOLTAGE_BITS-1:0];
    end else begin
      interp_v = (shifted > SH_BITS'(cur_v)) ? '0 : (cur_v - shifted[VOLTAGE_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_st <= cmd.res_stat;
      case (cmd.res_src)
        SRC_POINT:  res_v <= rd_volt;
        SRC_INTERP: res_v <= interp_v;
        default:    res_v <= '0;
      endcase
    end
    if (cmd.out_load) begin
      voltage_out <= res_v;
      status      <= res_st;
    end
  end

`ifndef NO_ASSERTIONS
  a_rd_next_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && cmd.rd_next) |-> !at_last)
    else $error("read of the next point beyond the usable points");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cmd.cursor_inc |-> !at_last)
    else $error("cursor stepped past the last usable point");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(div_busy && mul_busy))
    else $error("divider and multiplier busy together");
`endif

endmodule

// ===== hw/rtl/forward_piecewise_linear_interpolator.sv =====
// top level: forward-walking piecewise linear interpolator over a discharge curve
//
//  channel  role    beat carries                          taken when
//  item     sink    action, point_index, charge, voltage  item.valid & item.ready
//  result   source  voltage_out, status                   result.valid & result.ready
//  cfg      sink    points_in_use                         cfg.valid (ready always high)
//
// one item at a time; every item gives exactly one result beat
// load, restart and no-op items go straight to the finish state, which moves the result
//   into the output register once the result slot is free
// query: a hit on the current point is settled by a single point check, and each point
//   stepped over adds a walk step; a query inside the cached segment runs the serial
//   multiplier, and entering a new segment first runs the bit-serial slope divider
// curve memories need no clearing after reset; a stalled result holds in the
//   output register and a new item can be taken while it waits
module forward_piecewise_linear_interpolator
  import fpli_pkg::*;
#(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int CHARGE_BITS  = CHARGE_BITS_DEF,
  parameter int VOLTAGE_BITS = VOLTAGE_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  fpli_item_if.sink   item,
  fpli_result_if.source result,
  fpli_cfg_if.sink    cfg
);

  fpli_cmd_t  cmd;
  fpli_stat_t stat;

  // the register port never stalls
  assign cfg.ready = 1'b1;

  // sequencer: owns the walk mode and both handshakes
  fpli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .action    (item.action),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // curve storage, cursor, slope cache and arithmetic
  fpli_dp #(
    .MAX_POINTS   (MAX_POINTS),
    .CHARGE_BITS  (CHARGE_BITS),
    .VOLTAGE_BITS (VOLTAGE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .point_index (item.point_index),
    .charge      (item.charge),
    .voltage     (item.voltage),
    .cfg_valid   (cfg.valid),
    .cfg_points  (cfg.points_in_use),
    .voltage_out (result.voltage_out),
    .status      (result.status)
  );

endmodule

// ===== dv/fpli_curve_checker.sv =====
`timescale 1ns / 1ps
// checker: predicts every result beat of the interpolator and compares it field by field
module fpli_curve_checker
  import fpli_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  fpli_item_if   item,
  fpli_result_if result,
  fpli_cfg_if    cfg,
  output int     mismatches,
  output int     awaiting
);

  localparam int     POINTS      = MAX_POINTS_DEF;
  localparam int     ONE_Q16     = 1 << FRAC_BITS;
  localparam longint VOLT_CEIL   = (longint'(1) << VOLTAGE_BITS_DEF) - 1;
  localparam int     PRINT_LIMIT = 100;

  typedef struct packed {
    logic [VOLTAGE_BITS_DEF-1:0] volts;
    status_t                     st;
  } reading_t;

  logic [CHARGE_BITS_DEF-1:0]  knot_charge [POINTS];
  logic [VOLTAGE_BITS_DEF-1:0] knot_volts  [POINTS];
  logic [CHARGE_BITS_DEF-1:0]  seg_end_charge;
  int                          cursor;
  walk_mode_t                  mode;
  longint                      slope_q16;
  int                          points_limit;
  int                          beat_no;
  reading_t                    expected_readings [$];

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < PRINT_LIMIT)
      $display("[%0t] result beat %0d: %s got 0x%0h, expected 0x%0h",
               $time, beat_no, what, got, want);
    mismatches++;
  endtask

  // left knot voltage plus offset times cached slope, clipped to the voltage range
  function automatic logic [VOLTAGE_BITS_DEF-1:0] along_segment(
      input logic [CHARGE_BITS_DEF-1:0] q);
    longint qa, qb, offset, level;
    qa = q;
    qb = knot_charge[cursor];
    level = knot_volts[cursor];
    offset = qa - qb;
    // |offset| < 2^24 and |slope| < 2^32, so the product never leaves 64 bits
    level = level + (offset * slope_q16) / ONE_Q16;
    if (level < 0) level = 0;
    if (level > VOLT_CEIL) level = VOLT_CEIL;
    return level[VOLTAGE_BITS_DEF-1:0];
  endfunction

  function automatic void walk_query(input  logic [CHARGE_BITS_DEF-1:0]  q,
                                     output logic [VOLTAGE_BITS_DEF-1:0] volts,
                                     output status_t                     st);
    int     span;
    bit     settled;
    longint c_lo, c_hi, v_lo, v_hi;
    span = (points_limit > POINTS) ? POINTS : points_limit;
    volts = '0;
    st = STAT_OK;
    settled = 1'b0;
    case (mode)
      MODE_SEG: begin
        if (q < seg_end_charge) begin
          volts = along_segment(q);
          settled = 1'b1;
        end else if (cursor + 1 >= span) begin
          mode = MODE_POINT;
          st = STAT_ABOVE;
          settled = 1'b1;
        end else begin
          cursor++;
          if (q == knot_charge[cursor]) begin
            mode = MODE_POINT;
            volts = knot_volts[cursor];
            settled = 1'b1;
          end
        end
      end
      MODE_POINT: begin
        if (q == knot_charge[cursor]) begin
          volts = knot_volts[cursor];
          settled = 1'b1;
        end
      end
      default: begin
        cursor = 0;
        if (span == 0) begin
          st = STAT_EMPTY;
          settled = 1'b1;
        end else if (q < knot_charge[0]) begin
          st = STAT_BELOW;
          settled = 1'b1;
        end else if (q == knot_charge[0]) begin
          mode = MODE_POINT;
          volts = knot_volts[0];
          settled = 1'b1;
        end
      end
    endcase
    while (!settled) begin
      if (cursor + 1 >= span) begin
        mode = MODE_POINT;
        st = STAT_ABOVE;
        settled = 1'b1;
      end else if (q < knot_charge[cursor + 1]) begin
        c_lo = knot_charge[cursor];
        c_hi = knot_charge[cursor + 1];
        v_lo = knot_volts[cursor];
        v_hi = knot_volts[cursor + 1];
        slope_q16 = (c_hi > c_lo) ? ((v_hi - v_lo) * ONE_Q16) / (c_hi - c_lo) : 0;
        seg_end_charge = knot_charge[cursor + 1];
        mode = MODE_SEG;
        volts = along_segment(q);
        settled = 1'b1;
      end else begin
        cursor++;
        if (q == knot_charge[cursor]) begin
          mode = MODE_POINT;
          volts = knot_volts[cursor];
          settled = 1'b1;
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      cursor = 0;
      mode = MODE_START;
      slope_q16 = 0;
      seg_end_charge = '0;
      points_limit = 0;
      beat_no = 0;
      mismatches = 0;
      expected_readings.delete();
    end else begin
      // results first: a beat can never belong to the item taken on the same edge
      if (result.valid && result.ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("beat with nothing expected, status", result.status, 0);
        end else begin
          want = expected_readings.pop_front();
          if (result.voltage_out !== want.volts)
            report_mismatch("voltage_out", result.voltage_out, want.volts);
          if (result.status !== want.st)
            report_mismatch("status", result.status, want.st);
        end
        beat_no++;
      end
      if (cfg.valid && cfg.ready)
        points_limit = cfg.points_in_use;
      if (item.valid && item.ready) begin
        want.volts = '0;
        want.st = STAT_OK;
        case (action_t'(item.action))
          // the index field cannot exceed the table depth
          ACT_LOAD: begin
            knot_charge[item.point_index] = item.charge;
            knot_volts[item.point_index] = item.voltage;
          end
          ACT_QUERY: walk_query(item.charge, want.volts, want.st);
          ACT_RESTART: begin
            cursor = 0;
            mode = MODE_START;
            slope_q16 = 0;
            seg_end_charge = '0;
          end
          default: ;
        endcase
        expected_readings.push_back(want);
      end
    end
    awaiting = expected_readings.size();
  end

endmodule

// ===== dv/forward_piecewise_linear_interpolator_tb.sv =====
`timescale 1ns / 1ps
// testbench top: stimulus, reset, result back-pressure and verdict for the interpolator
module forward_piecewise_linear_interpolator_tb;
  import fpli_pkg::*;

  localparam int     POINTS       = MAX_POINTS_DEF;
  localparam int     RANDOM_ITEMS = 850;
  // the slowest legal gap between handshakes (long walk, divide, multiply,
  // longest receiver stall) stays well below this limit
  localparam int     QUIET_LIMIT  = 2000;
  localparam longint CHARGE_CEIL  = (longint'(1) << CHARGE_BITS_DEF) - 1;

  // receiver back-pressure styles
  typedef enum int {RX_OPEN, RX_COIN, RX_BLOCKS, RX_CADENCE} rx_style_t;

  logic clk = 1'b0;
  logic rst;

  fpli_item_if   item_ch ();
  fpli_result_if result_ch ();
  fpli_cfg_if    cfg_ch ();

  int mismatches;
  int awaiting;

  forward_piecewise_linear_interpolator dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  fpli_curve_checker curve_check (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stimulus-side picture of the curve, only used to aim queries at it
  logic [CHARGE_BITS_DEF-1:0] knot_shadow [POINTS];
  logic [CHARGE_BITS_DEF-1:0] last_query;
  int active_points = 0;
  int step_hint     = 1;
  int burst_left    = 0;
  int items_sent    = 0;

  // ---------------------------------------------------------------------------
  // receiver: stalls on a pattern of its own that changes style now and then
  // ---------------------------------------------------------------------------
  rx_style_t rx_style   = RX_OPEN;
  int        style_left = 0;
  int        stall_left = 0;
  int        rx_tick    = 0;

  always @(negedge clk) begin
    rx_tick++;
    if (style_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      style_left = $urandom_range(16, 256);
    end else begin
      style_left--;
    end
    case (rx_style)
      RX_OPEN: result_ch.ready <= 1'b1;
      RX_COIN: result_ch.ready <= 1'($urandom_range(0, 1));
      RX_BLOCKS: begin
        // mostly open, with the odd long block
        if (stall_left > 0) begin
          stall_left--;
          result_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(3, 40);
          result_ch.ready <= 1'b0;
        end else begin
          result_ch.ready <= 1'b1;
        end
      end
      default: result_ch.ready <= (rx_tick % 4) != 0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run if no channel moves a beat for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sender helpers
  // ---------------------------------------------------------------------------
  function automatic logic [CHARGE_BITS_DEF-1:0] clamp_charge(longint c);
    if (c < 0) return '0;
    if (c > CHARGE_CEIL) return CHARGE_BITS_DEF'(CHARGE_CEIL);
    return c[CHARGE_BITS_DEF-1:0];
  endfunction

  // one item beat; the sender works in bursts with random gaps between them
  task automatic send_item(action_t act, logic [5:0] idx, logic [CHARGE_BITS_DEF-1:0] q,
                           logic [VOLTAGE_BITS_DEF-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        // valid low with junk on the payload while idle
        @(negedge clk);
        item_ch.valid       <= 1'b0;
        item_ch.action      <= ACTION_BITS'($urandom());
        item_ch.point_index <= 6'($urandom());
        item_ch.charge      <= CHARGE_BITS_DEF'($urandom());
        item_ch.voltage     <= VOLTAGE_BITS_DEF'($urandom());
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    item_ch.valid       <= 1'b1;
    item_ch.action      <= act;
    item_ch.point_index <= idx;
    item_ch.charge      <= q;
    item_ch.voltage     <= v;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic query_at(logic [CHARGE_BITS_DEF-1:0] q);
    send_item(ACT_QUERY, 6'($urandom()), q, VOLTAGE_BITS_DEF'($urandom()));
  endtask

  task automatic restart_walk();
    send_item(ACT_RESTART, 6'($urandom()), CHARGE_BITS_DEF'($urandom()),
              VOLTAGE_BITS_DEF'($urandom()));
  endtask

  // drop valid and wait for every outstanding result beat
  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  // register write, only ever issued with the block drained
  task automatic write_points_in_use(int n);
    @(negedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.points_in_use <= 7'(n);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid         <= 1'b0;
    cfg_ch.points_in_use <= 7'($urandom());
  endtask

  // fills entries 0..n-1 so that no walk ever reads an unwritten knot
  task automatic load_curve(int n);
    longint c;
    int     delta;
    bit     falling;
    logic [VOLTAGE_BITS_DEF-1:0] v;
    case ($urandom_range(0, 3))
      0:       step_hint = 8;
      1:       step_hint = 4096;
      2:       step_hint = 65536;
      default: step_hint = (n > 1) ? (1 << CHARGE_BITS_DEF) / n : (1 << 23);
    endcase
    if ($urandom_range(0, 1) == 0) c = $urandom_range(0, 64);
    else c = $urandom_range(0, 1 << 22);
    v = VOLTAGE_BITS_DEF'($urandom());
    falling = $urandom_range(0, 3) != 0;
    for (int i = 0; i < n; i++) begin
      knot_shadow[i] = clamp_charge(c);
      send_item(ACT_LOAD, 6'(i), knot_shadow[i], v);
      // now and then a knot that does not rise
      delta = (
        $urandom_range(0, 23) == 0) ? -int'($urandom_range(0, step_hint)) :
        int'($urandom_range(1, step_hint));
      c = c + delta;
      // discharge curves mostly fall, wrapping gives the odd big jump
      if (falling) v = v - VOLTAGE_BITS_DEF'($urandom_range(0, 2048));
      else v = VOLTAGE_BITS_DEF'($urandom());
    end
  endtask

  // mostly a forward walk, with exact hits, backward steps and out-of-range charges
  function automatic logic [CHARGE_BITS_DEF-1:0] pick_query();
    int     r;
    longint c;
    r = $urandom_range(0, 99);
    c = last_query;
    if (active_points == 0 || r < 8) c = CHARGE_BITS_DEF'($urandom());
    else if (r < 20) c = knot_shadow[$urandom_range(0, active_points - 1)];
    else if (r < 28) c = c - int'($urandom_range(1, step_hint));
    else if (r < 33) c = longint'(knot_shadow[0]) - int'($urandom_range(0, 16));
    else if (r < 37) c = longint'(knot_shadow[active_points - 1]) + $urandom_range(0, 256);
    else c = c + $urandom_range(0, step_hint / 2 + 1);
    last_query = clamp_charge(c);
    return last_query;
  endfunction

  function automatic int pick_points();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 12) return 1;
    if (r < 20) return 2;
    if (r < 25) return POINTS;
    return $urandom_range(3, 12);
  endfunction

  // one setting of the register: new curve, then a walk with some noise mixed in
  task automatic run_phase(int n, bit rewind);
    int r;
    logic [5:0] idx;
    logic [CHARGE_BITS_DEF-1:0] q;
    drain();
    write_points_in_use(n);
    active_points = n;
    load_curve(n);
    // without a rewind the walk carries over, possibly past the shrunk table
    if (rewind) restart_walk();
    last_query = (n > 0) ? knot_shadow[0] : '0;
    repeat ($urandom_range(4, 36)) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        restart_walk();
        last_query = (n > 0) ? knot_shadow[0] : '0;
      end else if (r < 8) begin
        // stray load in the middle of a walk
        idx = 6'($urandom());
        q = CHARGE_BITS_DEF'($urandom());
        send_item(ACT_LOAD, idx, q, VOLTAGE_BITS_DEF'($urandom()));
        if (idx < n) knot_shadow[idx] = q;
      end else if (r < 10) begin
        send_item(ACT_NOP, 6'($urandom()), CHARGE_BITS_DEF'($urandom()),
                  VOLTAGE_BITS_DEF'($urandom()));
      end else begin
        query_at(pick_query());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int random_start;
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.action       = ACT_NOP;
    item_ch.point_index  = '0;
    item_ch.charge       = '0;
    item_ch.voltage      = '0;
    result_ch.ready      = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.points_in_use = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: table empty straight after reset, idle operation, rewind
    query_at('0);
    send_item(ACT_NOP, 6'h3f, '1, '1);
    restart_walk();

    // four knots: steep rise, fall, then a knot whose charge goes backwards;
    // the top entry holds the largest charge and voltage
    drain();
    write_points_in_use(4);
    send_item(ACT_LOAD, 6'd0, 24'h000010, 16'h0000);
    send_item(ACT_LOAD, 6'd1, 24'h000020, 16'hffff);
    send_item(ACT_LOAD, 6'd2, 24'h000040, 16'h8000);
    send_item(ACT_LOAD, 6'd3, 24'h000030, 16'h1234);
    send_item(ACT_LOAD, 6'd63, 24'hffffff, 16'hffff);
    query_at(24'h000000);   // below the first knot, walk stays at the start
    query_at(24'h000010);   // exact hit on the first knot
    query_at(24'h000008);   // behind the cursor, clipped at zero
    query_at(24'h000018);   // inside the cached segment
    send_item(ACT_LOAD, 6'd2, 24'h000040, 16'h0000);  // load mid-walk, walk undisturbed
    query_at(24'h00001c);   // cached slope still in use
    query_at(24'h000020);   // leaves the segment onto the second knot
    query_at(24'h00001f);   // backwards along a falling segment, clipped at full scale
    query_at(24'h000040);   // exact hit on the third knot from inside a segment
    query_at(24'h00002c);   // segment with a non-rising charge, flat slope
    query_at(24'hffffff);   // beyond the last knot
    query_at(24'h000030);   // exact hit on the last knot after the overrun
    restart_walk();
    query_at(24'h000030);   // fresh walk stepping over a knot into a segment

    // random part; the forced settings come first so the extremes are always hit
    random_start = items_sent;
    run_phase(POINTS, 1'b1);
    run_phase(1, 1'b0);
    run_phase(0, 1'b0);
    run_phase(2, 1'b1);
    while (items_sent - random_start < RANDOM_ITEMS)
      run_phase(pick_points(), $urandom_range(0, 4) != 0);

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
